>>> src/dipmd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package dipmd_pkg;

	localparam int SpeedW = 13;
	localparam int VoltW  = 12;
	localparam int GainW  = 10;
	localparam int LimW   = 13;
	localparam int DutyW  = 13;
	localparam int ErrW   = 14;
	localparam int AccW   = 14;
	localparam int DiffW  = 15;
	localparam int SumW   = 27;
	localparam int CfgIdxW  = 3;
	localparam int CfgDataW = 13;

	localparam logic [GainW-1:0] PropGainRst   = 10'd20;
	localparam logic [GainW-1:0] IntegGainRst  = 10'd30;
	localparam logic [LimW-1:0]  AccumLimitRst = 13'd7200;
	localparam logic [LimW-1:0]  DriveLimitRst = 13'd6900;
	localparam logic [VoltW-1:0] CutoffRst     = 12'd1110;

	typedef enum logic [CfgIdxW-1:0] {
		REG_PROP_GAIN   = 3'd0,
		REG_INTEG_GAIN  = 3'd1,
		REG_ACCUM_LIMIT = 3'd2,
		REG_DRIVE_LIMIT = 3'd3,
		REG_CUTOFF      = 3'd4
	} reg_idx_t;

	typedef struct packed {
		logic [GainW-1:0] prop_gain;
		logic [GainW-1:0] integ_gain;
		logic [LimW-1:0]  accum_limit;
		logic [LimW-1:0]  drive_limit;
		logic [VoltW-1:0] cutoff_voltage;
	} cfg_regs_t;

	typedef struct packed {
		logic [DutyW-1:0] duty;
		logic             reverse;
	} lane_out_t;

endpackage

`default_nettype wire

>>> src/dipmd_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface dipmd_in_if;
	logic                                   valid;
	logic                                   ready;
	logic signed [dipmd_pkg::SpeedW-1:0]    speed_a;
	logic signed [dipmd_pkg::SpeedW-1:0]    speed_b;
	logic signed [dipmd_pkg::SpeedW-1:0]    goal_a;
	logic signed [dipmd_pkg::SpeedW-1:0]    goal_b;
	logic        [dipmd_pkg::VoltW-1:0]     supply_voltage;

	modport source (output valid, speed_a, speed_b, goal_a, goal_b, supply_voltage,
		input ready);
	modport sink (input valid, speed_a, speed_b, goal_a, goal_b, supply_voltage,
		output ready);
endinterface

interface dipmd_out_if;
	logic                            valid;
	logic                            ready;
	logic [dipmd_pkg::DutyW-1:0]     duty_a;
	logic                            reverse_a;
	logic [dipmd_pkg::DutyW-1:0]     duty_b;
	logic                            reverse_b;
	logic                            shutdown;

	modport source (output valid, duty_a, reverse_a, duty_b, reverse_b, shutdown,
		input ready);
	modport sink (input valid, duty_a, reverse_a, duty_b, reverse_b, shutdown,
		output ready);
endinterface

interface dipmd_cfg_if;
	logic                               valid;
	logic                               ready;
	logic [dipmd_pkg::CfgIdxW-1:0]      index;
	logic [dipmd_pkg::CfgDataW-1:0]     data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

>>> src/dipmd_cfg_regs.sv
`timescale 1ns / 1ps
`default_nettype none

module dipmd_cfg_regs (
	input  wire                  clk,
	input  wire                  arst_n,
	dipmd_cfg_if.sink            cfg,
	output dipmd_pkg::cfg_regs_t regs
);

	dipmd_pkg::cfg_regs_t regs_q;

	assign cfg.ready = 1'b1;
	assign regs      = regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.prop_gain      <= dipmd_pkg::PropGainRst;
			regs_q.integ_gain     <= dipmd_pkg::IntegGainRst;
			regs_q.accum_limit    <= dipmd_pkg::AccumLimitRst;
			regs_q.drive_limit    <= dipmd_pkg::DriveLimitRst;
			regs_q.cutoff_voltage <= dipmd_pkg::CutoffRst;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				dipmd_pkg::REG_PROP_GAIN:
					regs_q.prop_gain <= cfg.data[dipmd_pkg::GainW-1:0];
				dipmd_pkg::REG_INTEG_GAIN:
					regs_q.integ_gain <= cfg.data[dipmd_pkg::GainW-1:0];
				dipmd_pkg::REG_ACCUM_LIMIT:
					regs_q.accum_limit <= cfg.data[dipmd_pkg::LimW-1:0];
				dipmd_pkg::REG_DRIVE_LIMIT:
					regs_q.drive_limit <= cfg.data[dipmd_pkg::LimW-1:0];
				dipmd_pkg::REG_CUTOFF:
					regs_q.cutoff_voltage <= cfg.data[dipmd_pkg::VoltW-1:0];
				default: begin
				end
			endcase
		end
	end

endmodule

`default_nettype wire

>>> src/dipmd_pi_lane.sv
`timescale 1ns / 1ps
`default_nettype none

module dipmd_pi_lane (
	input  wire                                     clk,
	input  wire                                     arst_n,
	input  wire                                     update,
	input  wire signed [dipmd_pkg::SpeedW-1:0]      speed,
	input  wire signed [dipmd_pkg::SpeedW-1:0]      goal,
	input  dipmd_pkg::cfg_regs_t                    regs,
	output dipmd_pkg::lane_out_t                    result
);

	logic signed [dipmd_pkg::AccW-1:0]  accum_q;
	logic signed [dipmd_pkg::ErrW-1:0]  prev_err_q;

	logic signed [dipmd_pkg::ErrW-1:0]  err;
	logic signed [dipmd_pkg::DiffW-1:0] diff;
	logic signed [dipmd_pkg::SumW-1:0]  p_term;
	logic signed [dipmd_pkg::SumW-1:0]  i_term;
	logic signed [dipmd_pkg::SumW-1:0]  sum;
	logic signed [dipmd_pkg::SumW-1:0]  acc_lim;
	logic signed [dipmd_pkg::AccW-1:0]  acc_next;
	logic signed [dipmd_pkg::AccW-1:0]  drv_lim;
	logic signed [dipmd_pkg::AccW-1:0]  drv;
	logic        [dipmd_pkg::AccW-1:0]  drv_mag;

	assign err  = dipmd_pkg::ErrW'(speed) - dipmd_pkg::ErrW'(goal);
	assign diff = dipmd_pkg::DiffW'(err) - dipmd_pkg::DiffW'(prev_err_q);

	// Gains are unsigned, so a zero sign bit goes in before the signed multiply.
	assign p_term = dipmd_pkg::SumW'(signed'({1'b0, regs.prop_gain}))
		* dipmd_pkg::SumW'(diff);
	assign i_term = dipmd_pkg::SumW'(signed'({1'b0, regs.integ_gain}))
		* dipmd_pkg::SumW'(err);
	assign sum     = dipmd_pkg::SumW'(accum_q) + p_term + i_term;
	assign acc_lim = dipmd_pkg::SumW'(signed'({1'b0, regs.accum_limit}));

	always_comb begin
		if (sum > acc_lim) begin
			acc_next = acc_lim[dipmd_pkg::AccW-1:0];
		end else if (sum < -acc_lim) begin
			acc_next = dipmd_pkg::AccW'(-acc_lim);
		end else begin
			acc_next = sum[dipmd_pkg::AccW-1:0];
		end
	end

	assign drv_lim = signed'({1'b0, regs.drive_limit});

	always_comb begin
		if (acc_next > drv_lim) begin
			drv = drv_lim;
		end else if (acc_next < -drv_lim) begin
			drv = -drv_lim;
		end else begin
			drv = acc_next;
		end
	end

	assign drv_mag        = drv[dipmd_pkg::AccW-1] ? dipmd_pkg::AccW'(-drv) : drv;
	assign result.duty    = drv_mag[dipmd_pkg::DutyW-1:0];
	assign result.reverse = (drv > dipmd_pkg::AccW'(0));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			accum_q    <= '0;
			prev_err_q <= '0;
		end else if (update) begin
			accum_q    <= acc_next;
			prev_err_q <= err;
		end
	end

endmodule

`default_nettype wire

>>> src/dual_incremental_pi_motor_drive_top.sv
// Dual incremental PI motor drive.
// The tick channel carries one control tick: measured and target speeds of
// wheels A and B and the supply voltage. The drive channel returns exactly one
// result per tick: duty magnitude and reverse bit per wheel plus a shutdown flag.
// The cfg channel writes the gains, the accumulator and drive limits and the
// cut-off voltage; it is always ready and should only be used while idle.
// A tick is taken into the tick register, passes through both PI lanes
// combinationally and is registered in the result register once that frees up.
// Throughput: one tick per cycle while the receiver does not stall. The
// accumulator update of both wheels is a single pass from the tick register to
// the result register, so consecutive ticks see each other's state with no gap.
// A tick whose supply voltage is below the cut-off gives zero drives with
// shutdown set and leaves both controllers untouched.
// Reset clears both accumulators and previous errors, loads the default gains
// and limits, and empties the tick and result registers.
// When the receiver stalls, the result is held; one further tick may still be
// taken into the tick register, after which ready drops until the result moves.
`timescale 1ns / 1ps
`default_nettype none

module dual_incremental_pi_motor_drive_top (
	input  wire          clk,
	input  wire          arst_n,
	dipmd_in_if.sink     tick,
	dipmd_out_if.source  drive,
	dipmd_cfg_if.sink    cfg
);

	dipmd_pkg::cfg_regs_t regs;
	dipmd_pkg::lane_out_t lane_a;
	dipmd_pkg::lane_out_t lane_b;

	logic                                 valid_s1;
	logic signed [dipmd_pkg::SpeedW-1:0]  speed_a_s1;
	logic signed [dipmd_pkg::SpeedW-1:0]  speed_b_s1;
	logic signed [dipmd_pkg::SpeedW-1:0]  goal_a_s1;
	logic signed [dipmd_pkg::SpeedW-1:0]  goal_b_s1;
	logic        [dipmd_pkg::VoltW-1:0]   volt_s1;

	logic                                 valid_s2;
	logic        [dipmd_pkg::DutyW-1:0]   duty_a_s2;
	logic                                 reverse_a_s2;
	logic        [dipmd_pkg::DutyW-1:0]   duty_b_s2;
	logic                                 reverse_b_s2;
	logic                                 shutdown_s2;

	logic advance;
	logic low_volt;
	logic update;

	dipmd_cfg_regs u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.regs   (regs)
	);

	// The result register frees up when it is empty or being taken this cycle.
	assign advance    = !valid_s2 || drive.ready;
	assign tick.ready = !valid_s1 || advance;
	assign low_volt   = (volt_s1 < regs.cutoff_voltage);
	assign update     = valid_s1 && advance && !low_volt;

	dipmd_pi_lane u_lane_a (
		.clk    (clk),
		.arst_n (arst_n),
		.update (update),
		.speed  (speed_a_s1),
		.goal   (goal_a_s1),
		.regs   (regs),
		.result (lane_a)
	);

	dipmd_pi_lane u_lane_b (
		.clk    (clk),
		.arst_n (arst_n),
		.update (update),
		.speed  (speed_b_s1),
		.goal   (goal_b_s1),
		.regs   (regs),
		.result (lane_b)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (tick.ready) begin
			valid_s1 <= tick.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (tick.valid && tick.ready) begin
			speed_a_s1 <= tick.speed_a;
			speed_b_s1 <= tick.speed_b;
			goal_a_s1  <= tick.goal_a;
			goal_b_s1  <= tick.goal_b;
			volt_s1    <= tick.supply_voltage;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			if (low_volt) begin
				duty_a_s2    <= '0;
				reverse_a_s2 <= 1'b0;
				duty_b_s2    <= '0;
				reverse_b_s2 <= 1'b0;
				shutdown_s2  <= 1'b1;
			end else begin
				duty_a_s2    <= lane_a.duty;
				reverse_a_s2 <= lane_a.reverse;
				duty_b_s2    <= lane_b.duty;
				reverse_b_s2 <= lane_b.reverse;
				shutdown_s2  <= 1'b0;
			end
		end
	end

	assign drive.valid     = valid_s2;
	assign drive.duty_a    = duty_a_s2;
	assign drive.reverse_a = reverse_a_s2;
	assign drive.duty_b    = duty_b_s2;
	assign drive.reverse_b = reverse_b_s2;
	assign drive.shutdown  = shutdown_s2;

`ifndef ASSERT_OFF
	a_shutdown_zero: assert property (@(posedge clk) disable iff (!arst_n)
		drive.valid && drive.shutdown |->
			drive.duty_a == '0 && drive.duty_b == '0
			&& !drive.reverse_a && !drive.reverse_b)
		else $error("shutdown result carries a nonzero drive");

	a_reverse_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		drive.valid && (drive.reverse_a || drive.reverse_b) |->
			(!drive.reverse_a || drive.duty_a != '0)
			&& (!drive.reverse_b || drive.duty_b != '0))
		else $error("reverse set with zero duty");

	a_duty_limit: assert property (@(posedge clk) disable iff (!arst_n)
		drive.valid |->
			drive.duty_a <= regs.drive_limit && drive.duty_b <= regs.drive_limit)
		else $error("duty exceeds drive limit");

	a_tick_held: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=>
			valid_s1 && $stable(speed_a_s1) && $stable(goal_a_s1) && $stable(volt_s1))
		else $error("tick register lost a stalled tick");
`endif

endmodule

`default_nettype wire

>>> tb/dual_incremental_pi_motor_drive_top_tb.sv
`timescale 1ns / 1ps

module dual_incremental_pi_motor_drive_top_tb;

	localparam int CycleLimit    = 200000;
	localparam int TicksPerPhase = 105;
	localparam int NumPhases     = 6;

	typedef struct {
		logic signed [dipmd_pkg::SpeedW-1:0] speed_a;
		logic signed [dipmd_pkg::SpeedW-1:0] speed_b;
		logic signed [dipmd_pkg::SpeedW-1:0] goal_a;
		logic signed [dipmd_pkg::SpeedW-1:0] goal_b;
		logic        [dipmd_pkg::VoltW-1:0]  volt;
	} tick_t;

	typedef struct {
		logic [dipmd_pkg::DutyW-1:0] duty_a;
		logic                        reverse_a;
		logic [dipmd_pkg::DutyW-1:0] duty_b;
		logic                        reverse_b;
		logic                        shutdown;
	} drive_t;

	typedef struct {
		tick_t  stim;
		bit     known;
		drive_t want;
	} dir_row_t;

	logic clk;
	logic arst_n;

	dipmd_in_if  tick_ch();
	dipmd_out_if drive_ch();
	dipmd_cfg_if cfg_ch();

	dual_incremental_pi_motor_drive_top dut (
		.clk    (clk),
		.arst_n (arst_n),
		.tick   (tick_ch),
		.drive  (drive_ch),
		.cfg    (cfg_ch)
	);

	// Shadow copy of the register file and of both wheel controllers.
	logic [dipmd_pkg::GainW-1:0] kp;
	logic [dipmd_pkg::GainW-1:0] ki;
	logic [dipmd_pkg::LimW-1:0]  acc_lim;
	logic [dipmd_pkg::LimW-1:0]  drv_lim;
	logic [dipmd_pkg::VoltW-1:0] cutoff;
	int                          acc_a;
	int                          err_a;
	int                          acc_b;
	int                          err_b;

	drive_t   pending_drive[$];
	dir_row_t directed[$];
	drive_t   blank_drive;

	int errors;
	int ticks_sent;
	int shutdown_ticks;
	int results_seen;
	int settings_used;
	int cycles;
	int stall_left;
	bit idle_on;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic int pi_advance(int speed, int goal, inout int acc, inout int prev_err);
		int err;
		int lim;
		int sum;
		err = speed - goal;
		lim = int'(acc_lim);
		sum = acc + int'(kp) * (err - prev_err) + int'(ki) * err;
		if (sum > lim) sum = lim;
		if (sum < -lim) sum = -lim;
		acc = sum;
		prev_err = err;
		return sum;
	endfunction

	function automatic void drive_of(int acc, output logic [dipmd_pkg::DutyW-1:0] duty,
			output logic rev);
		int d;
		int lim;
		lim = int'(drv_lim);
		d = acc;
		if (d < -lim) d = -lim;
		if (d > lim) d = lim;
		// The drive goes out negated, so a positive clamped value means reverse.
		rev = (d > 0);
		duty = dipmd_pkg::DutyW'((d < 0) ? -d : d);
	endfunction

	function automatic drive_t predict_drive(tick_t t);
		drive_t r;
		r.duty_a = '0;
		r.reverse_a = 1'b0;
		r.duty_b = '0;
		r.reverse_b = 1'b0;
		r.shutdown = 1'b0;
		if (t.volt < cutoff) begin
			r.shutdown = 1'b1;
			return r;
		end
		drive_of(pi_advance(int'(t.speed_a), int'(t.goal_a), acc_a, err_a),
			r.duty_a, r.reverse_a);
		drive_of(pi_advance(int'(t.speed_b), int'(t.goal_b), acc_b, err_b),
			r.duty_b, r.reverse_b);
		return r;
	endfunction

	function automatic void add_row(int sa, int sb, int ga, int gb, int v, bit known = 1'b0,
			int da = 0, bit ra = 1'b0, int db = 0, bit rb = 1'b0, bit sd = 1'b0);
		dir_row_t r;
		r.stim.speed_a = dipmd_pkg::SpeedW'(sa);
		r.stim.speed_b = dipmd_pkg::SpeedW'(sb);
		r.stim.goal_a = dipmd_pkg::SpeedW'(ga);
		r.stim.goal_b = dipmd_pkg::SpeedW'(gb);
		r.stim.volt = dipmd_pkg::VoltW'(v);
		r.known = known;
		r.want.duty_a = dipmd_pkg::DutyW'(da);
		r.want.reverse_a = ra;
		r.want.duty_b = dipmd_pkg::DutyW'(db);
		r.want.reverse_b = rb;
		r.want.shutdown = sd;
		directed.push_back(r);
	endfunction

	function automatic int clip_speed(int v);
		if (v > 4095) return 4095;
		if (v < -4096) return -4096;
		return v;
	endfunction

	function automatic int extreme_speed();
		case ($urandom_range(0, 3))
			0: return -4096;
			1: return 4095;
			2: return 0;
			default: return -1;
		endcase
	endfunction

	function automatic tick_t random_tick();
		tick_t t;
		int mode;
		int ga;
		int gb;
		mode = int'($urandom_range(0, 9));
		t.speed_a = dipmd_pkg::SpeedW'($urandom_range(0, 8191));
		t.speed_b = dipmd_pkg::SpeedW'($urandom_range(0, 8191));
		t.goal_a = dipmd_pkg::SpeedW'($urandom_range(0, 8191));
		t.goal_b = dipmd_pkg::SpeedW'($urandom_range(0, 8191));
		t.volt = dipmd_pkg::VoltW'($urandom_range(0, 4095));
		if (mode <= 5) begin
			// Speeds tracking their targets closely, with the supply healthy.
			ga = int'($urandom_range(0, 8191)) - 4096;
			gb = int'($urandom_range(0, 8191)) - 4096;
			t.goal_a = dipmd_pkg::SpeedW'(ga);
			t.goal_b = dipmd_pkg::SpeedW'(gb);
			t.speed_a = dipmd_pkg::SpeedW'(clip_speed(ga + int'($urandom_range(0, 80)) - 40));
			t.speed_b = dipmd_pkg::SpeedW'(clip_speed(gb + int'($urandom_range(0, 80)) - 40));
			t.volt = dipmd_pkg::VoltW'($urandom_range(cutoff, 4095));
		end else if (mode == 8) begin
			if (cutoff != 0) t.volt = dipmd_pkg::VoltW'($urandom_range(0, cutoff - 1));
		end else if (mode == 9) begin
			t.speed_a = dipmd_pkg::SpeedW'(extreme_speed());
			t.speed_b = dipmd_pkg::SpeedW'(extreme_speed());
			t.goal_a = dipmd_pkg::SpeedW'(extreme_speed());
			t.goal_b = dipmd_pkg::SpeedW'(extreme_speed());
		end
		return t;
	endfunction

	task automatic report_mismatch(string what, int got, int want);
		errors++;
		if (errors <= 30)
			$display("mismatch at cycle %0d: %s got %0d, expected %0d", cycles, what, got, want);
	endtask

	// Leaves valid high; the caller lowers it after the last write.
	task automatic write_reg(dipmd_pkg::reg_idx_t idx, int value);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data <= value[dipmd_pkg::CfgDataW-1:0];
		do @(posedge clk); while (!cfg_ch.ready);
		case (idx)
			dipmd_pkg::REG_PROP_GAIN:   kp = value[dipmd_pkg::GainW-1:0];
			dipmd_pkg::REG_INTEG_GAIN:  ki = value[dipmd_pkg::GainW-1:0];
			dipmd_pkg::REG_ACCUM_LIMIT: acc_lim = value[dipmd_pkg::LimW-1:0];
			dipmd_pkg::REG_DRIVE_LIMIT: drv_lim = value[dipmd_pkg::LimW-1:0];
			dipmd_pkg::REG_CUTOFF:      cutoff = value[dipmd_pkg::VoltW-1:0];
			default: ;
		endcase
	endtask

	task automatic apply_settings(int p_gain, int i_gain, int a_lim, int d_lim, int cut);
		write_reg(dipmd_pkg::REG_PROP_GAIN, p_gain);
		write_reg(dipmd_pkg::REG_INTEG_GAIN, i_gain);
		write_reg(dipmd_pkg::REG_ACCUM_LIMIT, a_lim);
		write_reg(dipmd_pkg::REG_DRIVE_LIMIT, d_lim);
		write_reg(dipmd_pkg::REG_CUTOFF, cut);
		cfg_ch.valid <= 1'b0;
		settings_used++;
	endtask

	task automatic pace();
		if (idle_on && $urandom_range(0, 3) == 0) begin
			tick_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 16)) @(posedge clk);
		end
	endtask

	task automatic send_tick(tick_t t, bit known, drive_t want);
		drive_t guess;
		tick_ch.valid <= 1'b1;
		tick_ch.speed_a <= t.speed_a;
		tick_ch.speed_b <= t.speed_b;
		tick_ch.goal_a <= t.goal_a;
		tick_ch.goal_b <= t.goal_b;
		tick_ch.supply_voltage <= t.volt;
		do @(posedge clk); while (!tick_ch.ready);
		// The controller state advances on every accepted request at or above the cut-off, typed rows included.
		guess = predict_drive(t);
		if (known)
			pending_drive.push_back(want);
		else
			pending_drive.push_back(guess);
		ticks_sent++;
		if (guess.shutdown) shutdown_ticks++;
	endtask

	always @(posedge clk) begin : drive_side
		drive_t want;
		if (arst_n && drive_ch.valid && drive_ch.ready) begin
			results_seen++;
			if (pending_drive.size() == 0) begin
				report_mismatch("result with nothing pending", 0, 0);
			end else begin
				want = pending_drive.pop_front();
				if (drive_ch.duty_a !== want.duty_a)
					report_mismatch("duty_a", int'(drive_ch.duty_a), int'(want.duty_a));
				if (drive_ch.reverse_a !== want.reverse_a)
					report_mismatch("reverse_a", int'(drive_ch.reverse_a),
						int'(want.reverse_a));
				if (drive_ch.duty_b !== want.duty_b)
					report_mismatch("duty_b", int'(drive_ch.duty_b), int'(want.duty_b));
				if (drive_ch.reverse_b !== want.reverse_b)
					report_mismatch("reverse_b", int'(drive_ch.reverse_b),
						int'(want.reverse_b));
				if (drive_ch.shutdown !== want.shutdown)
					report_mismatch("shutdown", int'(drive_ch.shutdown), int'(want.shutdown));
			end
		end
		if (stall_left > 0) begin
			stall_left--;
			drive_ch.ready <= 1'b0;
		end else if (idle_on && $urandom_range(0, 7) == 0) begin
			stall_left = int'($urandom_range(0, 15));
			drive_ch.ready <= 1'b0;
		end else begin
			drive_ch.ready <= 1'b1;
		end
	end

	initial begin
		cycles = 0;
		while (cycles < CycleLimit) begin
			@(posedge clk);
			cycles++;
		end
		$display("TB_ERROR");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		tick_ch.valid = 1'b0;
		tick_ch.speed_a = '0;
		tick_ch.speed_b = '0;
		tick_ch.goal_a = '0;
		tick_ch.goal_b = '0;
		tick_ch.supply_voltage = '0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = dipmd_pkg::REG_PROP_GAIN;
		cfg_ch.data = '0;
		drive_ch.ready = 1'b0;
		errors = 0;
		ticks_sent = 0;
		shutdown_ticks = 0;
		results_seen = 0;
		settings_used = 0;
		stall_left = 0;
		idle_on = 1'b1;
		kp = dipmd_pkg::PropGainRst;
		ki = dipmd_pkg::IntegGainRst;
		acc_lim = dipmd_pkg::AccumLimitRst;
		drv_lim = dipmd_pkg::DriveLimitRst;
		cutoff = dipmd_pkg::CutoffRst;
		acc_a = 0;
		err_a = 0;
		acc_b = 0;
		err_b = 0;

		// Rows with typed results rely on the reset state or on a shutdown tick.
		add_row(0, 0, 0, 0, 2000, 1'b1, 0, 1'b0, 0, 1'b0, 1'b0);
		add_row(4095, -4096, 0, 0, 0, 1'b1, 0, 1'b0, 0, 1'b0, 1'b1);
		add_row(4095, -4096, -4096, 4095, 4095, 1'b1, 6900, 1'b1, 6900, 1'b0, 1'b0);
		add_row(-4096, 4095, 4095, -4096, 1109, 1'b1, 0, 1'b0, 0, 1'b0, 1'b1);
		add_row(-4096, 4095, 4095, -4096, 1110);
		add_row(0, 0, 0, 0, 3000);
		add_row(100, -50, 90, -45, 1200);
		add_row(-1, 1, 0, 0, 1110);
		add_row(-1, 1, 0, 0, 1500);
		add_row(4095, -4096, 4095, -4096, 2048);
		add_row(10, -10, 0, 0, 4000);
		add_row(10, -10, 0, 0, 4000);
		add_row(-2000, 2000, 2000, -2000, 2047);
		add_row(-4096, -4096, -4096, -4096, 4095);
		add_row(4095, 4095, 4095, 4095, 0, 1'b1, 0, 1'b0, 0, 1'b0, 1'b1);
		add_row(5, 0, 0, 5, 1111);
		add_row(0, 0, 0, 0, 1110);
		add_row(-3, 7, 4, -2, 2730);

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		foreach (directed[i]) begin
			pace();
			send_tick(directed[i].stim, directed[i].known, directed[i].want);
		end

		for (int p = 1; p <= NumPhases; p++) begin
			tick_ch.valid <= 1'b0;
			while (pending_drive.size() != 0) @(posedge clk);
			idle_on = (p != NumPhases);
			case (p)
				1: apply_settings(0, 0, int'(dipmd_pkg::AccumLimitRst),
					int'(dipmd_pkg::DriveLimitRst), int'(dipmd_pkg::CutoffRst));
				2: apply_settings(1023, 1023, 8191, 8191, 0);
				3: apply_settings(5, 2, 0, 0, 4095);
				4: apply_settings(3, 1, 8191, 2000, 500);
				5: apply_settings(int'($urandom_range(0, 15)), int'($urandom_range(0, 7)),
					int'($urandom_range(0, 8191)), int'($urandom_range(0, 8191)),
					int'($urandom_range(0, 2000)));
				default: apply_settings(int'(dipmd_pkg::PropGainRst),
					int'(dipmd_pkg::IntegGainRst), int'(dipmd_pkg::AccumLimitRst),
					int'(dipmd_pkg::DriveLimitRst), int'(dipmd_pkg::CutoffRst));
			endcase
			for (int n = 0; n < TicksPerPhase; n++) begin
				pace();
				send_tick(random_tick(), 1'b0, blank_drive);
			end
		end
		tick_ch.valid <= 1'b0;

		while (pending_drive.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);

		$display("Drove %0d control ticks (%0d below cut-off) across %0d register settings.",
			ticks_sent, shutdown_ticks, settings_used);
		$display("Compared %0d drive results field by field, %0d mismatches.",
			results_seen, errors);
		if (errors == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
